// ===== rtl/atr_pkg.sv =====
// ----------------------------------------------------------------------------
// atr_pkg
// Shared types, sizes and codes for the AT response terminal recognizer.
// ----------------------------------------------------------------------------
package atr_pkg;

  // Store sizes
  localparam int LINE_DEPTH = 160;
  localparam int RESP_DEPTH = 256;

  localparam int LINE_AW  = $clog2(LINE_DEPTH);
  localparam int RESP_AW  = $clog2(RESP_DEPTH);
  localparam int RESP_FW  = $clog2(RESP_DEPTH + 1);
  localparam int LINE_LAST = LINE_DEPTH - 1;

  // Width for fill + separator + line + terminator against capacity
  localparam int SUM_W_RAW = $clog2(RESP_DEPTH + LINE_DEPTH + 2) + 1;
  localparam int SUM_W     = (SUM_W_RAW > 10) ? SUM_W_RAW : 10;

  // Field widths
  localparam int OP_W     = 2;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 3;
  localparam int CNT_W    = 16;
  localparam int CAP_W    = 9;
  localparam int LEN_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CNT_W-1:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [LEN_W-1:0] LEN_MAX       = 8'd255;

  // Line recognition
  localparam int HEAD_LEN = 5;
  localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;
  localparam logic [2*BYTE_W-1:0]        OK_TEXT    = "OK";
  localparam logic [HEAD_LEN*BYTE_W-1:0] ERROR_TEXT = "ERROR";

  typedef enum logic [OP_W-1:0] {
    OP_ARM  = 2'd0,
    OP_BYTE = 2'd1,
    OP_TICK = 2'd2,
    OP_READ = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_PENDING  = 3'd0,
    ST_OK       = 3'd1,
    ST_REFUSED  = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_TIMEOUT  = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT  = 2'd0,
    CFG_CAPACITY = 2'd1
  } cfg_reg_t;

  // Controller to datapath
  typedef struct packed {
    logic load_item;
    logic exec;
    logic copy;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic copy_start;
    logic copy_done;
  } sts_t;

endpackage

// ===== rtl/atr_if.sv =====
// ----------------------------------------------------------------------------
// atr_if
// Handshake channels: input items, result items, configuration writes.
// ----------------------------------------------------------------------------
interface atr_item_if;
  logic                         valid;
  logic                         ready;
  logic [atr_pkg::OP_W-1:0]     opcode;
  logic [atr_pkg::BYTE_W-1:0]   rx_byte;
  logic [atr_pkg::BYTE_W-1:0]   read_index;

  modport source (output valid, opcode, rx_byte, read_index, input ready);
  modport sink   (input valid, opcode, rx_byte, read_index, output ready);
endinterface

interface atr_result_if;
  logic                           valid;
  logic                           ready;
  logic [atr_pkg::STATUS_W-1:0]   status;
  logic [atr_pkg::LEN_W-1:0]      response_length;
  logic [atr_pkg::BYTE_W-1:0]     read_data;
  logic [atr_pkg::CNT_W-1:0]      refusal_count;
  logic [atr_pkg::CNT_W-1:0]      timeout_count;

  modport source (output valid, status, response_length, read_data, refusal_count,
                  timeout_count, input ready);
  modport sink   (input valid, status, response_length, read_data, refusal_count,
                  timeout_count, output ready);
endinterface

interface atr_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [atr_pkg::CFG_IDX_W-1:0]    reg_index;
  logic [atr_pkg::CFG_DATA_W-1:0]   wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ===== rtl/atr_ram.sv =====
// ----------------------------------------------------------------------------
// atr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module atr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/atr_datapath.sv =====
// ----------------------------------------------------------------------------
// atr_datapath
// Item registers, line and response stores, line recognition, counters
// and the result register.
// ----------------------------------------------------------------------------
module atr_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [atr_pkg::OP_W-1:0]          opcode,
  input  logic [atr_pkg::BYTE_W-1:0]        rx_byte,
  input  logic [atr_pkg::BYTE_W-1:0]        read_index,
  input  logic                              cfg_we,
  input  logic [atr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [atr_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  atr_pkg::cmd_t                     cmd,
  output atr_pkg::sts_t                     sts,
  output logic [atr_pkg::STATUS_W-1:0]      status,
  output logic [atr_pkg::LEN_W-1:0]         response_length,
  output logic [atr_pkg::BYTE_W-1:0]        read_data,
  output logic [atr_pkg::CNT_W-1:0]         refusal_count,
  output logic [atr_pkg::CNT_W-1:0]         timeout_count
);

  localparam int LAW = atr_pkg::LINE_AW;
  localparam int RAW = atr_pkg::RESP_AW;
  localparam int RFW = atr_pkg::RESP_FW;
  localparam int SW  = atr_pkg::SUM_W;
  localparam int BW  = atr_pkg::BYTE_W;

  // Item registers
  atr_pkg::op_t op_q;
  logic [BW-1:0] rx_q;
  logic [BW-1:0] idx_q;

  // Configuration
  logic [atr_pkg::CNT_W-1:0] timeout_ticks;
  logic [atr_pkg::CAP_W-1:0] capacity;

  // Exchange state
  logic [LAW-1:0]            line_fill;
  logic [LAW-1:0]            line_len;
  logic [BW-1:0]             head [atr_pkg::HEAD_LEN];
  logic [RFW-1:0]            resp_fill;
  logic [atr_pkg::CNT_W-1:0] elapsed;
  atr_pkg::status_t          outcome;
  logic [atr_pkg::CNT_W-1:0] refusal_total;
  logic [atr_pkg::CNT_W-1:0] timeout_total;

  // Copy sequencer
  logic [LAW-1:0] copy_rd;
  logic           copy_pend;

  // RAM ports
  logic           line_we;
  logic           line_re;
  logic [BW-1:0]  line_rdata;
  logic           resp_we;
  logic [BW-1:0]  resp_wdata;
  logic           resp_re;
  logic [BW-1:0]  resp_rdata;

  // Decode
  logic                      pending;
  logic                      is_eol;
  logic                      byte_go;
  logic                      line_end;
  logic                      byte_store;
  logic                      is_ok;
  logic                      is_err;
  logic                      sep;
  logic [SW-1:0]             cap_ext;
  logic [SW-1:0]             cap_eff;
  logic [SW-1:0]             need;
  logic                      no_room;
  logic                      append;
  logic [atr_pkg::CNT_W-1:0] tick_next;
  logic                      idx_valid;

  assign pending  = (outcome == atr_pkg::ST_PENDING);
  assign is_eol   = (rx_q == atr_pkg::CHAR_CR) || (rx_q == atr_pkg::CHAR_LF);
  assign byte_go  = cmd.exec && (op_q == atr_pkg::OP_BYTE) && pending;
  assign line_end = byte_go && is_eol && (line_fill != '0);
  assign byte_store = byte_go && !is_eol && (line_fill < LAW'(atr_pkg::LINE_LAST));

  assign is_ok  = (line_fill == LAW'(2)) && ({head[0], head[1]} == atr_pkg::OK_TEXT);
  assign is_err = (line_fill >= LAW'(atr_pkg::HEAD_LEN)) &&
                  ({head[0], head[1], head[2], head[3], head[4]} == atr_pkg::ERROR_TEXT);

  assign sep     = (resp_fill != '0);
  assign cap_ext = SW'(capacity);
  assign cap_eff = (cap_ext > SW'(atr_pkg::RESP_DEPTH)) ? SW'(atr_pkg::RESP_DEPTH) : cap_ext;
  assign need    = SW'(resp_fill) + SW'(sep) + SW'(line_fill) + SW'(1);
  assign no_room = (need > cap_eff);
  assign append  = line_end && !is_ok && !is_err && (capacity != '0) && !no_room;

  assign tick_next = elapsed + atr_pkg::CNT_W'(1);
  assign idx_valid = (SW'(idx_q) < SW'(resp_fill)) &&
                     (SW'(idx_q) < SW'(atr_pkg::RESP_DEPTH));

  assign sts.copy_start = append;
  assign sts.copy_done  = (copy_rd == line_len) && !copy_pend;

  // Store ports
  assign line_we    = byte_store;
  assign line_re    = cmd.copy && (copy_rd != line_len);
  assign resp_we    = (append && sep) || (cmd.copy && copy_pend);
  assign resp_wdata = (cmd.copy && copy_pend) ? line_rdata : atr_pkg::CHAR_LF;
  assign resp_re    = cmd.exec && (op_q == atr_pkg::OP_READ);

  atr_ram #(
    .WIDTH (BW),
    .DEPTH (atr_pkg::LINE_DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_fill),
    .wdata (rx_q),
    .re    (line_re),
    .raddr (copy_rd),
    .rdata (line_rdata)
  );

  atr_ram #(
    .WIDTH (BW),
    .DEPTH (atr_pkg::RESP_DEPTH)
  ) u_resp_ram (
    .clk   (clk),
    .we    (resp_we),
    .waddr (resp_fill[RAW-1:0]),
    .wdata (resp_wdata),
    .re    (resp_re),
    .raddr (RAW'(idx_q)),
    .rdata (resp_rdata)
  );

  // Item capture and line head (payload, no reset)
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_q  <= atr_pkg::op_t'(opcode);
      rx_q  <= rx_byte;
      idx_q <= read_index;
    end
    if (byte_store && (line_fill < LAW'(atr_pkg::HEAD_LEN))) begin
      head[line_fill[2:0]] <= rx_q;
    end
    if (line_end) begin
      line_len <= line_fill;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= atr_pkg::TIMEOUT_RESET;
      capacity      <= '0;
    end else if (cfg_we) begin
      unique case (atr_pkg::cfg_reg_t'(cfg_index))
        atr_pkg::CFG_TIMEOUT:  timeout_ticks <= cfg_data;
        atr_pkg::CFG_CAPACITY: capacity      <= cfg_data[atr_pkg::CAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Exchange state and copy sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      line_fill     <= '0;
      resp_fill     <= '0;
      elapsed       <= '0;
      outcome       <= atr_pkg::ST_PENDING;
      refusal_total <= '0;
      timeout_total <= '0;
      copy_rd       <= '0;
      copy_pend     <= 1'b0;
    end else begin
      if (cmd.exec) begin
        case (op_q)
          atr_pkg::OP_ARM: begin
            line_fill <= '0;
            resp_fill <= '0;
            elapsed   <= '0;
            outcome   <= atr_pkg::ST_PENDING;
          end
          atr_pkg::OP_BYTE: begin
            if (pending) begin
              if (is_eol) begin
                if (line_fill != '0) begin
                  line_fill <= '0;
                  if (is_ok) begin
                    outcome <= atr_pkg::ST_OK;
                  end else if (is_err) begin
                    refusal_total <= refusal_total + atr_pkg::CNT_W'(1);
                    outcome       <= atr_pkg::ST_REFUSED;
                  end else if (capacity != '0) begin
                    if (no_room) begin
                      outcome <= atr_pkg::ST_OVERFLOW;
                    end else begin
                      // separator goes in now, line bytes follow in the copy
                      if (sep) begin
                        resp_fill <= resp_fill + RFW'(1);
                      end
                      copy_rd   <= '0;
                      copy_pend <= 1'b0;
                    end
                  end
                end
              end else if (byte_store) begin
                line_fill <= line_fill + LAW'(1);
              end else begin
                outcome <= atr_pkg::ST_OVERFLOW;
              end
            end
          end
          atr_pkg::OP_TICK: begin
            if (pending) begin
              elapsed <= tick_next;
              if (tick_next >= timeout_ticks) begin
                timeout_total <= timeout_total + atr_pkg::CNT_W'(1);
                outcome       <= atr_pkg::ST_TIMEOUT;
              end
            end
          end
          default: ;
        endcase
      end

      if (cmd.copy) begin
        // issue one line read per cycle, write back the byte read last cycle
        copy_pend <= line_re;
        if (line_re) begin
          copy_rd <= copy_rd + LAW'(1);
        end
        if (copy_pend) begin
          resp_fill <= resp_fill + RFW'(1);
        end
      end
    end
  end

  // Result register (payload)
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status          <= outcome;
      response_length <= (SW'(resp_fill) > SW'(atr_pkg::LEN_MAX)) ?
                         atr_pkg::LEN_MAX : resp_fill[atr_pkg::LEN_W-1:0];
      read_data       <= ((op_q == atr_pkg::OP_READ) && idx_valid) ? resp_rdata : '0;
      refusal_count   <= refusal_total;
      timeout_count   <= timeout_total;
    end
  end

endmodule

// ===== rtl/atr_ctrl.sv =====
// ----------------------------------------------------------------------------
// atr_ctrl
// Sequencing state machine: take item, execute, copy line, deliver result.
// ----------------------------------------------------------------------------
module atr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  atr_pkg::sts_t sts,
  output atr_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_COPY = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = sts.copy_start ? S_COPY : S_DONE;
      end
      S_COPY: begin
        cmd.copy = 1'b1;
        if (sts.copy_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the result register is free
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/at_response_terminal_recognizer_core.sv =====
// ----------------------------------------------------------------------------
// at_response_terminal_recognizer_core
// Watches modem reply bytes, ticks and reads; one result item per input item.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  items     in   valid/ready    opcode, rx_byte, read_index
//  results   out  valid/ready    status, response_length, read_data,
//                                refusal_count, timeout_count
//  cfg       in   valid/ready    reg_index, wdata (0 timeout, 1 capacity)
//
//  Arm, byte, tick and read items pass from accept through execute and done to result valid.
//  A line appended to the response also passes through the copy state: the line store
//  read port copies one byte per cycle into the response store.
//  Reset is synchronous; the stores need no clearing pass.
//  A stalled result holds in the output register while the next item is
//  accepted and processed; that item's result waits until the register frees.
// ----------------------------------------------------------------------------
module at_response_terminal_recognizer_core (
  input  logic                clk,
  input  logic                rst,
  atr_item_if.sink            items,
  atr_result_if.source        results,
  atr_cfg_if.sink             cfg
);

  atr_pkg::cmd_t cmd;
  atr_pkg::sts_t sts;

  assign cfg.ready = 1'b1;

  atr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  atr_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .opcode          (items.opcode),
    .rx_byte         (items.rx_byte),
    .read_index      (items.read_index),
    .cfg_we          (cfg.valid),
    .cfg_index       (cfg.reg_index),
    .cfg_data        (cfg.wdata),
    .cmd             (cmd),
    .sts             (sts),
    .status          (results.status),
    .response_length (results.response_length),
    .read_data       (results.read_data),
    .refusal_count   (results.refusal_count),
    .timeout_count   (results.timeout_count)
  );

`ifndef NO_ASSERTIONS
  // An accepted item is executed before any result can be loaded
  a_no_load_after_accept: assert property (@(posedge clk) disable iff (rst)
    (items.valid && items.ready) |=> !cmd.load_out)
    else $error("result loaded in the cycle after an item was accepted");

  // No second item is taken while one is in flight
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (items.valid && items.ready) |=> !items.ready)
    else $error("item accepted while previous item still executing");

  // Line copy never overlaps item intake
  a_copy_blocks_intake: assert property (@(posedge clk) disable iff (rst)
    cmd.copy |-> !items.ready)
    else $error("input ready during line copy");

  // A copy only starts from execution of an item
  a_copy_follows_exec: assert property (@(posedge clk) disable iff (rst)
    (cmd.copy && !$past(cmd.copy)) |-> $past(cmd.exec && sts.copy_start))
    else $error("line copy started without a line end");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives arm, byte, tick and read items into the AT response recognizer and
// checks every status report against a cycle-free model of the exchange, over
// several timeout and capacity settings and several idling patterns.
// ----------------------------------------------------------------------------
module testbench;
  import atr_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int N_PHASES    = 7;

  typedef struct packed {
    status_t           status;
    logic [LEN_W-1:0]  response_length;
    logic [BYTE_W-1:0] read_data;
    logic [CNT_W-1:0]  refusal_count;
    logic [CNT_W-1:0]  timeout_count;
  } report_t;

  typedef struct {
    op_t               op;
    logic [BYTE_W-1:0] rx;
    logic [BYTE_W-1:0] idx;
    bit                typed;
    report_t           want;
  } dir_row_t;

  typedef struct {
    logic [CFG_DATA_W-1:0] timeout;
    logic [CFG_DATA_W-1:0] capacity;
    int unsigned           gap_pct;
    int unsigned           stall_pct;
    int unsigned           n_items;
    bit                    long_line;
    bit                    fill_up;
  } phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  atr_item_if   item_ch ();
  atr_result_if result_ch ();
  atr_cfg_if    cfg_ch ();

  at_response_terminal_recognizer_core i_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (item_ch),
    .results (result_ch),
    .cfg     (cfg_ch)
  );

  // Exchange model state
  logic [BYTE_W-1:0] line_buf [LINE_DEPTH];
  logic [BYTE_W-1:0] resp_buf [RESP_DEPTH];
  int unsigned       line_cnt = 0;
  int unsigned       resp_cnt = 0;
  logic [CNT_W-1:0]  tick_cnt = '0;
  status_t           outcome_q = ST_PENDING;
  logic [CNT_W-1:0]  refusal_tot = '0;
  logic [CNT_W-1:0]  timeout_tot = '0;
  logic [CNT_W-1:0]  cfg_timeout = TIMEOUT_RESET;
  logic [CAP_W-1:0]  cfg_capacity = '0;

  report_t     awaited_reports [$];
  report_t     oldest_report;
  int unsigned bad_fields = 0;
  int unsigned items_sent = 0;
  int unsigned idle_cycles = 0;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned phase_end;

  dir_row_t directed_rows [24] = '{
    '{OP_READ, 8'h00, 8'h00, 1'b1, '{ST_PENDING, 8'd0, 8'd0, 16'd0, 16'd0}},
    '{OP_TICK, 8'hFF, 8'hFF, 1'b1, '{ST_PENDING, 8'd0, 8'd0, 16'd0, 16'd0}},
    '{OP_BYTE, "O",   8'h00, 1'b0, '0},
    '{OP_BYTE, "K",   8'hFF, 1'b0, '0},
    '{OP_BYTE, CHAR_CR, 8'h00, 1'b1, '{ST_OK, 8'd0, 8'd0, 16'd0, 16'd0}},
    '{OP_BYTE, 8'hFF, 8'h00, 1'b1, '{ST_OK, 8'd0, 8'd0, 16'd0, 16'd0}},
    '{OP_TICK, 8'h00, 8'h00, 1'b1, '{ST_OK, 8'd0, 8'd0, 16'd0, 16'd0}},
    '{OP_ARM,  8'hFF, 8'hFF, 1'b1, '{ST_PENDING, 8'd0, 8'd0, 16'd0, 16'd0}},
    '{OP_BYTE, CHAR_LF, 8'h00, 1'b1, '{ST_PENDING, 8'd0, 8'd0, 16'd0, 16'd0}},
    '{OP_BYTE, "E",   8'h00, 1'b0, '0},
    '{OP_BYTE, "R",   8'h00, 1'b0, '0},
    '{OP_BYTE, "R",   8'h00, 1'b0, '0},
    '{OP_BYTE, "O",   8'h00, 1'b0, '0},
    '{OP_BYTE, "R",   8'h00, 1'b0, '0},
    '{OP_BYTE, 8'h00, 8'h00, 1'b0, '0},
    '{OP_BYTE, CHAR_CR, 8'h00, 1'b1, '{ST_REFUSED, 8'd0, 8'd0, 16'd1, 16'd0}},
    '{OP_READ, 8'h00, 8'hFF, 1'b1, '{ST_REFUSED, 8'd0, 8'd0, 16'd1, 16'd0}},
    '{OP_ARM,  8'h00, 8'h00, 1'b1, '{ST_PENDING, 8'd0, 8'd0, 16'd1, 16'd0}},
    '{OP_BYTE, "O",   8'h00, 1'b0, '0},
    '{OP_BYTE, "K",   8'h00, 1'b0, '0},
    '{OP_BYTE, "!",   8'h00, 1'b0, '0},
    '{OP_BYTE, CHAR_LF, 8'h00, 1'b0, '0},
    '{OP_READ, 8'hFF, 8'hFF, 1'b0, '0},
    '{OP_TICK, 8'h00, 8'h00, 1'b0, '0}
  };

  phase_t phases [N_PHASES] = '{
    '{16'd20,    16'd64,  0,  0,  40,  1'b0, 1'b0},
    '{16'd1,     16'd256, 70, 0,  35,  1'b0, 1'b0},
    '{16'd0,     16'd16,  0,  70, 35,  1'b0, 1'b0},
    '{16'd65535, 16'd256, 16, 16, 100, 1'b1, 1'b0},
    '{16'd7,     16'd400, 0,  0,  60,  1'b0, 1'b1},
    '{16'd200,   16'd40,  0,  70, 30,  1'b0, 1'b0},
    '{16'd1000,  16'd0,   70, 0,  30,  1'b0, 1'b0}
  };

  initial begin
    forever #1 clk = ~clk;
  end

  // Apply one item to the exchange model and return the report it causes
  function automatic report_t track_exchange(op_t op, logic [BYTE_W-1:0] rx,
                                             logic [BYTE_W-1:0] idx);
    report_t     r;
    int unsigned len;
    int unsigned cap;
    int unsigned sep;
    int unsigned k;
    r = '0;
    case (op)
      OP_ARM: begin
        line_cnt  = 0;
        resp_cnt  = 0;
        tick_cnt  = '0;
        outcome_q = ST_PENDING;
      end
      OP_BYTE: begin
        if (outcome_q == ST_PENDING) begin
          if (rx == CHAR_CR || rx == CHAR_LF) begin
            if (line_cnt != 0) begin
              len      = line_cnt;
              line_cnt = 0;
              if (len == 2 && line_buf[0] == OK_TEXT[15:8] &&
                  line_buf[1] == OK_TEXT[7:0]) begin
                outcome_q = ST_OK;
              end else if (len >= HEAD_LEN && {line_buf[0], line_buf[1], line_buf[2],
                                                line_buf[3], line_buf[4]} == ERROR_TEXT) begin
                refusal_tot = refusal_tot + 1'b1;
                outcome_q   = ST_REFUSED;
              end else if (cfg_capacity != 0) begin
                cap = (cfg_capacity > RESP_DEPTH) ? RESP_DEPTH : cfg_capacity;
                sep = (resp_cnt > 0) ? 1 : 0;
                if (resp_cnt + sep + len + 1 > cap) begin
                  outcome_q = ST_OVERFLOW;
                end else begin
                  if (sep != 0) begin
                    resp_buf[resp_cnt] = CHAR_LF;
                    resp_cnt++;
                  end
                  for (k = 0; k < len; k++) begin
                    resp_buf[resp_cnt] = line_buf[k];
                    resp_cnt++;
                  end
                end
              end
            end
          end else if (line_cnt < LINE_LAST) begin
            line_buf[line_cnt] = rx;
            line_cnt++;
          end else begin
            outcome_q = ST_OVERFLOW;
          end
        end
      end
      OP_TICK: begin
        if (outcome_q == ST_PENDING) begin
          tick_cnt = tick_cnt + 1'b1;
          if (tick_cnt >= cfg_timeout) begin
            timeout_tot = timeout_tot + 1'b1;
            outcome_q   = ST_TIMEOUT;
          end
        end
      end
      default: begin
        if (idx < resp_cnt) r.read_data = resp_buf[idx];
      end
    endcase
    r.status          = outcome_q;
    r.response_length = (resp_cnt > 255) ? LEN_MAX : 8'(resp_cnt);
    r.refusal_count   = refusal_tot;
    r.timeout_count   = timeout_tot;
    return r;
  endfunction

  function automatic logic [BYTE_W-1:0] text_byte();
    logic [BYTE_W-1:0] b;
    do b = 8'($urandom_range(255)); while (b == CHAR_CR || b == CHAR_LF);
    return b;
  endfunction

  // Mostly inside the collected text, sometimes anywhere
  function automatic logic [BYTE_W-1:0] pick_index();
    int unsigned top;
    top = (resp_cnt + 1 > 255) ? 255 : resp_cnt + 1;
    if ($urandom_range(3) == 0) return 8'($urandom_range(255));
    return 8'($urandom_range(top));
  endfunction

  // Returns right after the accepting edge; the next caller lowers or reuses valid
  task automatic send_item(input op_t op, input logic [BYTE_W-1:0] rx,
                           input logic [BYTE_W-1:0] idx, input bit typed = 1'b0,
                           input report_t want = '0);
    report_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid      <= 1'b1;
    item_ch.opcode     <= op;
    item_ch.rx_byte    <= rx;
    item_ch.read_index <= idx;
    do @(posedge clk); while (!item_ch.ready);
    predicted = track_exchange(op, rx, idx);
    awaited_reports.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (awaited_reports.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t which, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= which;
    cfg_ch.wdata     <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (which)
      CFG_TIMEOUT:  cfg_timeout  = value;
      CFG_CAPACITY: cfg_capacity = value[CAP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_item(OP_BYTE, s[i], 8'($urandom_range(255)));
  endtask

  // One line of text, then CR, LF or CR LF; noisy lines mix in ticks, reads, raw bytes
  task automatic send_line(input int unsigned len, input bit noisy);
    int unsigned       j;
    logic [BYTE_W-1:0] b;
    for (j = 0; j < len; j++) begin
      if (noisy && $urandom_range(9) == 0) begin
        send_item(OP_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)));
      end
      if (noisy && $urandom_range(9) == 0) begin
        send_item(OP_READ, 8'($urandom_range(255)), pick_index());
      end
      b = (noisy && $urandom_range(15) == 0) ? 8'($urandom_range(255)) : text_byte();
      send_item(OP_BYTE, b, 8'($urandom_range(255)));
    end
    case ($urandom_range(2))
      0: send_item(OP_BYTE, CHAR_CR, 8'($urandom_range(255)));
      1: send_item(OP_BYTE, CHAR_LF, 8'($urandom_range(255)));
      default: begin
        send_item(OP_BYTE, CHAR_CR, 8'($urandom_range(255)));
        send_item(OP_BYTE, CHAR_LF, 8'($urandom_range(255)));
      end
    endcase
  endtask

  task automatic run_exchange(input bit long_line, input bit fill_up);
    int unsigned k;
    int unsigned n_lines;
    if ($urandom_range(29) == 0) wait_drained();
    send_item(OP_ARM, 8'($urandom_range(255)), 8'($urandom_range(255)));
    if (long_line) begin
      // overrun the line buffer without a terminator
      for (k = 0; k < LINE_DEPTH + 2; k++) begin
        send_item(OP_BYTE, text_byte(), 8'($urandom_range(255)));
      end
      send_item(OP_BYTE, CHAR_CR, 8'h00);
    end else if (fill_up) begin
      // 150 + 1 + 104 fills the store to 255, one more line cannot fit
      send_line(150, 1'b0);
      send_line(104, 1'b0);
      send_item(OP_READ, 8'($urandom_range(255)), 8'd254);
      send_item(OP_READ, 8'($urandom_range(255)), 8'd255);
      send_line(1, 1'b0);
      send_item(OP_READ, 8'($urandom_range(255)), 8'd0);
    end else begin
      n_lines = $urandom_range(4);
      for (k = 0; k < n_lines; k++) begin
        send_line(($urandom_range(7) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12),
                  1'b1);
      end
      case ($urandom_range(3))
        0: begin
          send_text("OK");
          send_item(OP_BYTE, CHAR_CR, 8'($urandom_range(255)));
        end
        1: begin
          send_text("ERROR");
          send_line($urandom_range(6), 1'b1);
        end
        2: begin
          repeat ($urandom_range(1, 40)) begin
            send_item(OP_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)));
          end
        end
        default: begin
          // near misses of the terminal lines
          if ($urandom_range(1) == 0) send_text("ERRO");
          else send_text("O");
          send_line($urandom_range(3), 1'b1);
        end
      endcase
    end
    repeat ($urandom_range(4)) begin
      send_item(op_t'($urandom_range(3)), 8'($urandom_range(255)), pick_index());
    end
  endtask

  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      result_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (awaited_reports.size() == 0) begin
        $error("report arrived with no item outstanding");
        bad_fields++;
      end else begin
        oldest_report = awaited_reports.pop_front();
        if (result_ch.status !== oldest_report.status) begin
          $error("status: expected %0d, got %0d", oldest_report.status, result_ch.status);
          bad_fields++;
        end
        if (result_ch.response_length !== oldest_report.response_length) begin
          $error("response_length: expected %0d, got %0d",
                 oldest_report.response_length, result_ch.response_length);
          bad_fields++;
        end
        if (result_ch.read_data !== oldest_report.read_data) begin
          $error("read_data: expected 0x%02h, got 0x%02h",
                 oldest_report.read_data, result_ch.read_data);
          bad_fields++;
        end
        if (result_ch.refusal_count !== oldest_report.refusal_count) begin
          $error("refusal_count: expected %0d, got %0d",
                 oldest_report.refusal_count, result_ch.refusal_count);
          bad_fields++;
        end
        if (result_ch.timeout_count !== oldest_report.timeout_count) begin
          $error("timeout_count: expected %0d, got %0d",
                 oldest_report.timeout_count, result_ch.timeout_count);
          bad_fields++;
        end
      end
    end
  end

  // Count cycles in which no channel moves
  always @(posedge clk) begin
    if (((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
         (cfg_ch.valid && cfg_ch.ready)) === 1'b1) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    item_ch.valid      = 1'b0;
    item_ch.opcode     = OP_ARM;
    item_ch.rx_byte    = '0;
    item_ch.read_index = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.reg_index   = CFG_TIMEOUT;
    cfg_ch.wdata       = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].op, directed_rows[i].rx, directed_rows[i].idx,
                directed_rows[i].typed, directed_rows[i].want);
    end

    foreach (phases[p]) begin
      wait_drained();
      write_reg(CFG_TIMEOUT, phases[p].timeout);
      write_reg(CFG_CAPACITY, phases[p].capacity);
      @(negedge clk);
      cfg_ch.valid <= 1'b0;
      gap_pct    = phases[p].gap_pct;
      stall_pct  = phases[p].stall_pct;
      phase_end  = items_sent + phases[p].n_items;
      if (phases[p].long_line) run_exchange(1'b1, 1'b0);
      if (phases[p].fill_up) run_exchange(1'b0, 1'b1);
      while (items_sent < phase_end) run_exchange(1'b0, 1'b0);
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (bad_fields == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/atr_pkg.sv
rtl/atr_if.sv
rtl/atr_ram.sv
rtl/atr_datapath.sv
rtl/atr_ctrl.sv
rtl/at_response_terminal_recognizer_core.sv
tb/testbench.sv
